/* hdl/raster_to_lcd_bank_bytes_top_defines.svh */
// Assertion macros used by the checker of the vertical bank byte packer.
`ifndef RASTER_TO_LCD_BANK_BYTES_TOP_DEFINES_SVH
`define RASTER_TO_LCD_BANK_BYTES_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define RLBB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rlbb check failed");

// Next-cycle implication, switched off while reset is held.
`define RLBB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rlbb check failed");

// Same-cycle implication that is also checked during reset.
`define RLBB_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("rlbb check failed");

`endif

/* hdl/rlbb_pkg.sv */
// Shared constants and types of the vertical bank byte packer.
package rlbb_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 64;

  localparam int COL_W  = 7;   // column position bits
  localparam int ROW_W  = 6;   // row position bits
  localparam int WCFG_W = 8;   // width register bits
  localparam int HCFG_W = 7;   // height register bits
  localparam int ACC_W  = 7;   // rows 0..6 of a bank

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // One pixel with its position resolved, passed from the tracker to the packer.
  typedef struct packed {
    logic             dot;
    logic [COL_W-1:0] col;
    logic [2:0]       row_in_bank;
    logic [2:0]       bank;
    logic             active;    // row lies inside a whole bank
    logic             last;      // last column of the last whole bank
  } item_t;

  // Finished column byte from the packer.
  typedef struct packed {
    logic             emit;
    logic [7:0]       column_byte;
    logic [COL_W-1:0] column_index;
    logic [2:0]       bank_index;
    logic             last_of_frame;
  } result_t;

endpackage

/* hdl/rlbb_pos.sv */
// Configuration registers and raster position tracker.
module rlbb_pos (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                accept,
  input  logic [7:0]          pixel,
  input  logic                first_of_frame,
  output rlbb_pkg::item_t     item
);

  logic [rlbb_pkg::WCFG_W-1:0] width_r;
  logic [rlbb_pkg::HCFG_W-1:0] height_r;
  logic [rlbb_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [rlbb_pkg::ROW_W-1:0]  row_r, row_nxt;

  logic [rlbb_pkg::WCFG_W-1:0] w_eff;
  logic [rlbb_pkg::HCFG_W-1:0] h_eff, h_wrap;
  logic [3:0]                  banks;
  logic [rlbb_pkg::COL_W-1:0]  col0, col_c;
  logic [rlbb_pkg::ROW_W-1:0]  row0;
  logic [rlbb_pkg::WCFG_W-1:0] col_inc;
  logic [rlbb_pkg::ROW_W:0]    row_inc;

  // Configuration writes; the position is kept across them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rlbb_pkg::WCFG_W'(84);
      height_r <= rlbb_pkg::HCFG_W'(48);
    end else if (cfg_we) begin
      case (cfg_index)
        rlbb_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        rlbb_pkg::REG_HEIGHT: height_r <= cfg_wdata[rlbb_pkg::HCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: width clamped to 1..MAX_WIDTH, height to MAX_HEIGHT.
  always_comb begin
    if (width_r == '0) begin
      w_eff = rlbb_pkg::WCFG_W'(1);
    end else if (width_r > rlbb_pkg::WCFG_W'(rlbb_pkg::MAX_WIDTH)) begin
      w_eff = rlbb_pkg::WCFG_W'(rlbb_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r > rlbb_pkg::HCFG_W'(rlbb_pkg::MAX_HEIGHT)) begin
      h_eff = rlbb_pkg::HCFG_W'(rlbb_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    h_wrap = (h_eff == '0) ? rlbb_pkg::HCFG_W'(1) : h_eff;
    banks  = h_eff[rlbb_pkg::HCFG_W-1:3];
  end

  // Resolve the position of this pixel and the next one.
  always_comb begin
    col0 = first_of_frame ? '0 : col_r;
    row0 = first_of_frame ? '0 : row_r;
    if ({1'b0, col0} >= w_eff) begin
      col_c = rlbb_pkg::COL_W'(w_eff - 8'd1);
    end else begin
      col_c = col0;
    end

    item.dot         = pixel[0];
    item.col         = col_c;
    item.row_in_bank = row0[2:0];
    item.bank        = row0[rlbb_pkg::ROW_W-1:3];
    item.active      = ({1'b0, row0[rlbb_pkg::ROW_W-1:3]} < banks);
    item.last        = ({1'b0, col_c} == (w_eff - 8'd1)) &&
                       ({1'b0, row0[rlbb_pkg::ROW_W-1:3]} == (banks - 4'd1));

    col_inc = {1'b0, col_c} + 8'd1;
    row_inc = {1'b0, row0} + 7'd1;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_wrap) ? '0 : row_inc[rlbb_pkg::ROW_W-1:0];
    end else begin
      col_nxt = col_inc[rlbb_pkg::COL_W-1:0];
      row_nxt = row0;
    end
  end

  // Position registers advance on every accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* hdl/rlbb_acc.sv */
// Column accumulator memory with its read-modify-write stage.
module rlbb_acc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,   // new item enters the stage
  input  logic              advance,  // stage item completes this cycle
  input  rlbb_pkg::item_t   item,
  output logic              stg_valid,
  output rlbb_pkg::result_t result
);

  logic [rlbb_pkg::ACC_W-1:0] acc_mem [rlbb_pkg::MAX_WIDTH];

  logic                       stg_valid_r;
  rlbb_pkg::item_t            stg_r;
  logic [rlbb_pkg::ACC_W-1:0] rd_r;
  logic                       byp_r;
  logic [rlbb_pkg::ACC_W-1:0] byp_data_r;

  logic [rlbb_pkg::ACC_W-1:0] old_bits, new_bits;
  logic                       wr_en;

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (accept) begin
      stg_valid_r <= 1'b1;
    end else if (advance) begin
      stg_valid_r <= 1'b0;
    end
  end

  // Capture the item and read its column; a write to the same column in this
  // cycle is forwarded since the memory still holds the older value.
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r      <= item;
      rd_r       <= acc_mem[item.col];
      byp_r      <= wr_en && (stg_r.col == item.col);
      byp_data_r <= new_bits;
    end
  end

  // Merge the dot into the accumulated rows.
  always_comb begin
    old_bits = byp_r ? byp_data_r : rd_r;
    if (stg_r.row_in_bank == 3'd0) begin
      new_bits = rlbb_pkg::ACC_W'(stg_r.dot);
    end else begin
      new_bits = old_bits | (rlbb_pkg::ACC_W'(stg_r.dot) << stg_r.row_in_bank);
    end
    wr_en = advance && stg_r.active && (stg_r.row_in_bank != 3'd7);
  end

  // Write back rows 0..6 of the bank.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[stg_r.col] <= new_bits;
    end
  end

  // The eighth row completes the column byte.
  always_comb begin
    result.emit          = stg_valid_r && stg_r.active && (stg_r.row_in_bank == 3'd7);
    result.column_byte   = {stg_r.dot, old_bits};
    result.column_index  = stg_r.col;
    result.bank_index    = stg_r.bank;
    result.last_of_frame = stg_r.last;
  end

  assign stg_valid = stg_valid_r;

endmodule

/* hdl/raster_to_lcd_bank_bytes_top.sv */
// Top level of the raster to LCD vertical bank byte packer.
//
//   channel | direction | tdata (low bit up)                      | side band
//   in_     | slave     | pixel[7:0]                              | tuser: first_of_frame
//   out_    | master    | column_byte, column_index, bank_index   | tlast: last_of_frame
//   cfg_    | write     | cfg_wdata: width (8 b) or height (7 b)  | cfg_index 0/1
//
// One pixel word is accepted per clock while the stage can advance; its byte
// passes through the accumulator read stage and then the output register.
// The accumulator is a 128 x 7 single-write memory; each pixel of rows 0..6 of
// a whole bank does one read-modify-write, with same-column forwarding for
// back-to-back access. rst_n is synchronous, resets position and configuration
// and clears valid flags. A stalled output holds its word; input keeps flowing
// while the held pixel produces no byte or the output register is free.
module raster_to_lcd_bank_bytes_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  input  logic        in_tuser,   // [0] first_of_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] column_byte, [14:8] column_index,
                                  // [17:15] bank_index, [23:18] zero
  output logic        out_tlast,  // last_of_frame
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  rlbb_pkg::item_t   item;
  rlbb_pkg::result_t result;
  logic              stg_valid;
  logic              advance;
  logic              accept;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic [6:0]        out_col_r;
  logic [2:0]        out_bank_r;
  logic              out_last_r;

  // Stage completes when it holds an item, unless it holds a byte and the output register is full and stalled.
  assign advance   = stg_valid && (!result.emit || !out_valid_r || out_tready);
  assign in_tready = !stg_valid || advance;
  assign accept    = in_tvalid && in_tready;

  rlbb_pos u_pos (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .accept         (accept),
    .pixel          (in_tdata),
    .first_of_frame (in_tuser),
    .item           (item)
  );

  rlbb_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .advance   (advance),
    .item      (item),
    .stg_valid (stg_valid),
    .result    (result)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_byte_r <= result.column_byte;
      out_col_r  <= result.column_index;
      out_bank_r <= result.bank_index;
      out_last_r <= result.last_of_frame;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_bank_r, out_col_r, out_byte_r};
  assign out_tlast  = out_last_r;

endmodule

/* hdl/rlbb_checker.sv */
// Port-level checker of the bank byte packer, bound to the top level.
`include "raster_to_lcd_bank_bytes_top_defines.svh"

module rlbb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // The cycle after reset shows no byte.
  `RLBB_ASSERT_ALWAYS(a_no_out_after_reset, clk, $past(rst_n) == 1'b0, !out_tvalid)

  // A held output word keeps its contents until taken.
  `RLBB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // With the output register empty the input side never stalls.
  `RLBB_ASSERT_NOW(a_in_free, clk, rst_n, !out_tvalid, in_tready)

  // Padding bits of the output word stay zero.
  `RLBB_ASSERT_NOW(a_out_pad, clk, rst_n, out_tvalid, out_tdata[23:18] == 6'd0)

endmodule

bind raster_to_lcd_bank_bytes_top rlbb_checker u_rlbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
